/* design/urldec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_pkg
// shared types, character constants and entity lookup functions
// ----------------------------------------------------------------------------
package urldec_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ONE   = 8'h01;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

	// prefix of a pending entity
	typedef enum logic [15:0] {
		EP_NONE = 16'h0001,
		EP_AND  = 16'h0002,
		EP_A    = 16'h0004,
		EP_AP   = 16'h0008,
		EP_APO  = 16'h0010,
		EP_APOS = 16'h0020,
		EP_AM   = 16'h0040,
		EP_AMP  = 16'h0080,
		EP_G    = 16'h0100,
		EP_GT   = 16'h0200,
		EP_L    = 16'h0400,
		EP_LT   = 16'h0800,
		EP_Q    = 16'h1000,
		EP_QU   = 16'h2000,
		EP_QUO  = 16'h4000,
		EP_QUOT = 16'h8000
	} ent_t;

	typedef struct packed {
		ent_t       nx;
		logic       done;
		logic [7:0] repl;
	} ent_step_t;

	// one front-end request: up to three symbols for the entity stage
	typedef struct packed {
		logic [2:0][7:0] syms;
		logic [1:0]      cnt;
		logic            last;
	} q_ent_t;

	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= "0" && c <= "9") begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= "a" && c <= "f") begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= "A" && c <= "F") begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [2:0] held_len(input ent_t st);
		logic [2:0] r;
		unique case (st)
			EP_AND:                               r = 3'd1;
			EP_A, EP_G, EP_L, EP_Q:               r = 3'd2;
			EP_AP, EP_AM, EP_GT, EP_LT, EP_QU:    r = 3'd3;
			EP_APO, EP_AMP, EP_QUO:               r = 3'd4;
			EP_APOS, EP_QUOT:                     r = 3'd5;
			default:                              r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [39:0] held_str(input ent_t st);
		logic [39:0] r;
		unique case (st)
			EP_AND:  r = {"&", 32'h0};
			EP_A:    r = {"&a", 24'h0};
			EP_AP:   r = {"&ap", 16'h0};
			EP_APO:  r = {"&apo", 8'h0};
			EP_APOS: r = "&apos";
			EP_AM:   r = {"&am", 16'h0};
			EP_AMP:  r = {"&amp", 8'h0};
			EP_G:    r = {"&g", 24'h0};
			EP_GT:   r = {"&gt", 16'h0};
			EP_L:    r = {"&l", 24'h0};
			EP_LT:   r = {"&lt", 16'h0};
			EP_Q:    r = {"&q", 24'h0};
			EP_QU:   r = {"&qu", 16'h0};
			EP_QUO:  r = {"&quo", 8'h0};
			EP_QUOT: r = "&quot";
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] held_char(input ent_t st, input logic [2:0] idx);
		logic [39:0] s;
		s = held_str(st);
		return s[39 - 8 * idx -: 8];
	endfunction

	function automatic ent_step_t ent_next(input ent_t st, input logic [7:0] c);
		ent_step_t r;
		r.nx   = EP_NONE;
		r.done = 1'b0;
		r.repl = CH_AMP;
		unique case (st)
			EP_AND: begin
				if (c == "a") r.nx = EP_A;
				else if (c == "g") r.nx = EP_G;
				else if (c == "l") r.nx = EP_L;
				else if (c == "q") r.nx = EP_Q;
			end
			EP_A: begin
				if (c == "p") r.nx = EP_AP;
				else if (c == "m") r.nx = EP_AM;
			end
			EP_AP:  if (c == "o") r.nx = EP_APO;
			EP_APO: if (c == "s") r.nx = EP_APOS;
			EP_APOS: begin
				r.done = (c == CH_SEMI);
				r.repl = CH_APOS;
			end
			EP_AM:  if (c == "p") r.nx = EP_AMP;
			EP_AMP: begin
				r.done = (c == CH_SEMI);
				r.repl = CH_AMP;
			end
			EP_G:   if (c == "t") r.nx = EP_GT;
			EP_GT: begin
				r.done = (c == CH_SEMI);
				r.repl = CH_GT;
			end
			EP_L:   if (c == "t") r.nx = EP_LT;
			EP_LT: begin
				r.done = (c == CH_SEMI);
				r.repl = CH_LT;
			end
			EP_Q:   if (c == "u") r.nx = EP_QU;
			EP_QU:  if (c == "o") r.nx = EP_QUO;
			EP_QUO: if (c == "t") r.nx = EP_QUOT;
			EP_QUOT: begin
				r.done = (c == CH_SEMI);
				r.repl = CH_QUOT;
			end
			default: ;
		endcase
		return r;
	endfunction

endpackage

/* design/urldec_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_in_if
// encoded byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface urldec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* design/urldec_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_out_if
// decoded byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface urldec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* design/urldec_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_front
// percent and plus decoding, one input byte per cycle into the request queue while it is not full
// ----------------------------------------------------------------------------
module urldec_front (
	input  logic                 clk,
	input  logic                 arst_n,
	urldec_in_if.sink            enc,
	input  logic                 q_full,
	output logic                 q_push,
	output urldec_pkg::q_ent_t   q_wdata
);
	import urldec_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_PCT  = 3'b010,
		PH_DIG  = 3'b100
	} ph_t;

	ph_t             ph_q, ph_n;
	logic [7:0]      dig_q, dig_n;
	logic [2:0][7:0] s;
	logic [1:0]      n;
	logic [4:0]      hb, hd;
	logic [7:0]      v;
	logic            take_b;
	logic            acc;

	assign enc.ready = !q_full;
	assign acc       = enc.valid && !q_full;

	always_comb begin
		s      = '0;
		n      = '0;
		ph_n   = ph_q;
		dig_n  = dig_q;
		take_b = 1'b1;
		v      = '0;
		hb     = hex_dec(enc.in_byte);
		hd     = hex_dec(dig_q);
		unique case (ph_q)
			PH_PCT: begin
				if (hb[4]) begin
					ph_n   = PH_DIG;
					dig_n  = enc.in_byte;
					take_b = 1'b0;
				end else begin
					s[n] = CH_PCT;
					n    = n + 2'd1;
					ph_n = PH_IDLE;
				end
			end
			PH_DIG: begin
				if (hb[4]) begin
					v = {hd[3:0], hb[3:0]};
					if (v != CH_ONE && v < CH_CTRL_LIMIT) v = CH_SPACE;
					s[n]   = v;
					n      = n + 2'd1;
					ph_n   = PH_IDLE;
					take_b = 1'b0;
				end else begin
					s[n] = CH_PCT;
					n    = n + 2'd1;
					s[n] = dig_q;
					n    = n + 2'd1;
					ph_n = PH_IDLE;
				end
			end
			PH_IDLE: ;
			default: ;
		endcase
		if (take_b) begin
			if (enc.in_byte == CH_PCT) begin
				ph_n = PH_PCT;
			end else if (enc.in_byte == CH_PLUS) begin
				s[n] = CH_SPACE;
				n    = n + 2'd1;
			end else begin
				s[n] = enc.in_byte;
				n    = n + 2'd1;
			end
		end
		// end of string: anything held goes out literally
		if (enc.in_last) begin
			if (ph_n == PH_PCT) begin
				s[n] = CH_PCT;
				n    = n + 2'd1;
			end else if (ph_n == PH_DIG) begin
				s[n] = CH_PCT;
				n    = n + 2'd1;
				s[n] = dig_n;
				n    = n + 2'd1;
			end
			ph_n  = PH_IDLE;
			dig_n = '0;
		end
	end

	assign q_push       = acc && (n != 2'd0);
	assign q_wdata.syms = s;
	assign q_wdata.cnt  = n;
	assign q_wdata.last = enc.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			dig_q <= '0;
		end else if (acc) begin
			ph_q  <= ph_n;
			dig_q <= dig_n;
		end
	end

endmodule

/* design/urldec_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_fifo
// short request queue between the front and back ends
// ----------------------------------------------------------------------------
module urldec_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  urldec_pkg::q_ent_t   wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output urldec_pkg::q_ent_t   head
);
	import urldec_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	q_ent_t        mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			if (do_pop) rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* design/urldec_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urldec_back
// entity matcher with held-prefix flush, one output byte per cycle unless the output stalls
// ----------------------------------------------------------------------------
module urldec_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  urldec_pkg::q_ent_t   q_head,
	output logic                 q_pop,
	urldec_out_if.source         dec
);
	import urldec_pkg::*;

	ent_t       ep_q, ep_n;
	logic [1:0] si_q, si_n;
	logic       fl_q, fl_n;
	ent_t       fl_st_q, fl_st_n;
	logic [2:0] fl_idx_q, fl_idx_n;
	logic       fl_fin_q, fl_fin_n;
	logic       dv_q;
	logic [7:0] db_q;
	logic       dl_q;

	logic       can_go, emit, el, adv, is_end;
	logic [7:0] eb, c;
	ent_step_t  en;

	assign can_go = !dv_q || dec.ready;
	assign c      = q_head.syms[si_q];
	assign is_end = (si_q == q_head.cnt - 2'd1);
	assign en     = ent_next(ep_q, c);

	always_comb begin
		emit     = 1'b0;
		eb       = c;
		el       = 1'b0;
		adv      = 1'b0;
		q_pop    = 1'b0;
		ep_n     = ep_q;
		si_n     = si_q;
		fl_n     = fl_q;
		fl_st_n  = fl_st_q;
		fl_idx_n = fl_idx_q;
		fl_fin_n = fl_fin_q;
		if (can_go) begin
			if (fl_q) begin
				emit = 1'b1;
				eb   = held_char(fl_st_q, fl_idx_q);
				if (fl_idx_q == held_len(fl_st_q) - 3'd1) begin
					fl_n = 1'b0;
					el   = fl_fin_q;
				end else begin
					fl_idx_n = fl_idx_q + 3'd1;
				end
			end else if (q_valid) begin
				if (ep_q != EP_NONE && en.done) begin
					emit = 1'b1;
					eb   = en.repl;
					ep_n = EP_NONE;
					adv  = 1'b1;
				end else if (ep_q != EP_NONE && en.nx != EP_NONE) begin
					ep_n = en.nx;
					adv  = 1'b1;
				end else if (ep_q != EP_NONE) begin
					// failed match: flush the prefix, then retry this byte
					emit = 1'b1;
					eb   = CH_AMP;
					if (held_len(ep_q) > 3'd1) begin
						fl_n     = 1'b1;
						fl_st_n  = ep_q;
						fl_idx_n = 3'd1;
						fl_fin_n = 1'b0;
					end
					ep_n = EP_NONE;
				end else if (c == CH_AMP) begin
					ep_n = EP_AND;
					adv  = 1'b1;
				end else begin
					emit = 1'b1;
					eb   = c;
					adv  = 1'b1;
				end
				if (adv) begin
					if (is_end) begin
						q_pop = 1'b1;
						si_n  = '0;
						if (q_head.last) begin
							if (ep_n == EP_NONE) begin
								el = 1'b1;
							end else begin
								emit = 1'b1;
								eb   = CH_AMP;
								if (held_len(ep_n) > 3'd1) begin
									fl_n     = 1'b1;
									fl_st_n  = ep_n;
									fl_idx_n = 3'd1;
									fl_fin_n = 1'b1;
								end else begin
									el = 1'b1;
								end
								ep_n = EP_NONE;
							end
						end
					end else begin
						si_n = si_q + 2'd1;
					end
				end
			end
		end
	end

	assign dec.valid    = dv_q;
	assign dec.out_byte = db_q;
	assign dec.out_last = dl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ep_q     <= EP_NONE;
			si_q     <= '0;
			fl_q     <= 1'b0;
			fl_st_q  <= EP_NONE;
			fl_idx_q <= '0;
			fl_fin_q <= 1'b0;
			dv_q     <= 1'b0;
		end else begin
			ep_q     <= ep_n;
			si_q     <= si_n;
			fl_q     <= fl_n;
			fl_st_q  <= fl_st_n;
			fl_idx_q <= fl_idx_n;
			fl_fin_q <= fl_fin_n;
			if (emit) dv_q <= 1'b1;
			else if (dec.ready) dv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			db_q <= eb;
			dl_q <= el;
		end
	end

endmodule

/* design/url_percent_and_entity_decoder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_and_entity_decoder_top
// Decodes '+' and %xx escapes, then the entities &apos; &amp; &gt; &lt; and
// &quot;, one input byte per cycle while the request queue has room. The
// back end sends one output byte per cycle unless the output stalls, so a
// byte that yields more than one output byte keeps it busy (a failed entity
// flushes its held prefix, up to five bytes, and a broken escape gives up to
// three); the request queue of QUEUE_DEPTH entries lets the front end keep
// taking bytes during such bursts. Each byte passes through the request
// queue and the output register; out_last marks a string's final byte.
// ----------------------------------------------------------------------------
module url_percent_and_entity_decoder_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	urldec_in_if.sink     enc,
	urldec_out_if.source  dec
);
	import urldec_pkg::*;

	logic   q_full, q_push, q_pop, q_valid;
	q_ent_t q_wdata, q_head;

	urldec_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.enc     (enc),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	urldec_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	urldec_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.dec     (dec)
	);

endmodule

/* sim/url_percent_and_entity_decoder_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_and_entity_decoder_top_test
// Drives encoded strings into the decoder through a randomly paced driver,
// predicts the decoded bytes and last marks for every accepted request, and
// checks each decoded request against the oldest prediction. Directed strings
// cover zero and all-ones bytes, escapes in both cases, forced spaces, the
// kept value 1, broken and trailing escapes and failed entities; random
// strings mix whole and cut entities, escapes, '+' and arbitrary bytes.
// ----------------------------------------------------------------------------
module url_percent_and_entity_decoder_top_test;
	import urldec_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 95;

	typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_phase_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         drain;
	} enc_req_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} dec_req_t;

	logic clk;
	logic arst_n;

	urldec_in_if  enc_if ();
	urldec_out_if dec_if ();

	url_percent_and_entity_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc_if),
		.dec    (dec_if)
	);

	enc_req_t   enc_q[$];
	dec_req_t   decoded_q[$];
	logic [7:0] str_q[$];
	logic [7:0] step_out[$];

	esc_phase_t esc_phase = ESC_IDLE;
	logic [7:0] esc_digit = '0;
	ent_t       ent_st = EP_NONE;

	string      ent_name[5] = '{"&apos;", "&amp;", "&gt;", "&lt;", "&quot;"};
	logic [7:0] ent_char[5] = '{CH_APOS, CH_AMP, CH_GT, CH_LT, CH_QUOT};
	ent_t       prefix_st[15] = '{EP_AND, EP_A, EP_AP, EP_APO, EP_APOS, EP_AM,
		EP_AMP, EP_G, EP_GT, EP_L, EP_LT, EP_Q, EP_QU, EP_QUO, EP_QUOT};

	int         err_cnt = 0;
	int         cycle_cnt = 0;
	int         in_gap = 0;
	int         in_calm = 0;
	int         out_stall = 0;
	int         out_calm = 0;
	int         rand_items = 0;
	int         str_cnt = 0;
	enc_req_t   cur;
	dec_req_t   want;

	// ------------------------------------------------------------------------
	// decode prediction
	// ------------------------------------------------------------------------
	function automatic int hex_val(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic string held_prefix(ent_t st);
		case (st)
			EP_AND:  return "&";
			EP_A:    return "&a";
			EP_AP:   return "&ap";
			EP_APO:  return "&apo";
			EP_APOS: return "&apos";
			EP_AM:   return "&am";
			EP_AMP:  return "&amp";
			EP_G:    return "&g";
			EP_GT:   return "&gt";
			EP_L:    return "&l";
			EP_LT:   return "&lt";
			EP_Q:    return "&q";
			EP_QU:   return "&qu";
			EP_QUO:  return "&quo";
			EP_QUOT: return "&quot";
			default: return "";
		endcase
	endfunction

	// true when target is base followed by exactly c
	function automatic bit grows_into(string base, logic [7:0] c, string target);
		if (target.len() != base.len() + 1) return 1'b0;
		return target.substr(0, base.len() - 1) == base && target[base.len()] == c;
	endfunction

	task automatic ent_flush();
		string h;
		h = held_prefix(ent_st);
		for (int i = 0; i < h.len(); i++) step_out.push_back(h[i]);
		ent_st = EP_NONE;
	endtask

	task automatic ent_push(logic [7:0] c);
		string h;
		if (ent_st != EP_NONE) begin
			h = held_prefix(ent_st);
			for (int i = 0; i < 5; i++) begin
				if (grows_into(h, c, ent_name[i])) begin
					step_out.push_back(ent_char[i]);
					ent_st = EP_NONE;
					return;
				end
			end
			for (int i = 0; i < 15; i++) begin
				if (grows_into(h, c, held_prefix(prefix_st[i]))) begin
					ent_st = prefix_st[i];
					return;
				end
			end
			ent_flush();
		end
		if (c == CH_AMP) ent_st = EP_AND;
		else step_out.push_back(c);
	endtask

	task automatic decode_byte(logic [7:0] b, logic last);
		int hi;
		int lo;
		int v;
		bit used;
		used = 1'b0;
		step_out.delete();
		if (esc_phase == ESC_PCT) begin
			if (hex_val(b) >= 0) begin
				esc_digit = b;
				esc_phase = ESC_DIGIT;
				used = 1'b1;
			end else begin
				ent_push(CH_PCT);
				esc_phase = ESC_IDLE;
			end
		end else if (esc_phase == ESC_DIGIT) begin
			lo = hex_val(b);
			if (lo >= 0) begin
				hi = hex_val(esc_digit);
				v = hi * 16 + lo;
				if (v != int'(CH_ONE) && v < int'(CH_CTRL_LIMIT)) v = int'(CH_SPACE);
				esc_phase = ESC_IDLE;
				ent_push(v[7:0]);
				used = 1'b1;
			end else begin
				ent_push(CH_PCT);
				ent_push(esc_digit);
				esc_phase = ESC_IDLE;
			end
		end
		if (!used) begin
			if (b == CH_PCT) esc_phase = ESC_PCT;
			else if (b == CH_PLUS) ent_push(CH_SPACE);
			else ent_push(b);
		end
		if (last) begin
			if (esc_phase == ESC_PCT) begin
				ent_push(CH_PCT);
			end else if (esc_phase == ESC_DIGIT) begin
				ent_push(CH_PCT);
				ent_push(esc_digit);
			end
			esc_phase = ESC_IDLE;
			esc_digit = '0;
			ent_flush();
		end
		for (int k = 0; k < step_out.size(); k++)
			decoded_q.push_back('{b: step_out[k], last: last && k == step_out.size() - 1});
	endtask

	// ------------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------------
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) calm = $urandom_range(8, 30);
		return $urandom_range(0, 6);
	endfunction

	function automatic logic [7:0] rand_hex();
		string hx;
		hx = "0123456789abcdefABCDEF";
		return hx[$urandom_range(0, 21)];
	endfunction

	function automatic logic [7:0] rand_nonhex();
		string nh;
		nh = "gG+&%z;xq ";
		return nh[$urandom_range(0, nh.len() - 1)];
	endfunction

	task automatic append_text(string s);
		for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
	endtask

	task automatic queue_string(bit drain);
		for (int i = 0; i < str_q.size(); i++)
			enc_q.push_back('{b: str_q[i], last: i == str_q.size() - 1, drain: drain && i == 0});
		str_q.delete();
	endtask

	task automatic add_random_token();
		string n;
		int cut;
		case ($urandom_range(0, 9))
			0, 1: append_text(ent_name[$urandom_range(0, 4)]);
			2: begin
				// cut entity followed by a breaking byte
				n = ent_name[$urandom_range(0, 4)];
				cut = $urandom_range(1, n.len() - 1);
				append_text(n.substr(0, cut - 1));
				case ($urandom_range(0, 3))
					0: str_q.push_back(CH_AMP);
					1: str_q.push_back(CH_SEMI);
					2: str_q.push_back(8'($urandom_range(int'("a"), int'("z"))));
					default: str_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			3, 4: begin
				str_q.push_back(CH_PCT);
				if ($urandom_range(0, 2) == 0) str_q.push_back($urandom_range(0, 1) ? "1" : "0");
				else str_q.push_back(rand_hex());
				str_q.push_back(rand_hex());
			end
			5: begin
				str_q.push_back(CH_PCT);
				if ($urandom_range(0, 1)) str_q.push_back(rand_hex());
				str_q.push_back(rand_nonhex());
			end
			6: str_q.push_back(CH_PLUS);
			7, 8: str_q.push_back(8'($urandom_range(32, 126)));
			default: str_q.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	// ------------------------------------------------------------------------
	// clock, stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		string n;
		arst_n = 1'b0;

		// zero byte, all-ones byte
		str_q.push_back(8'h00);
		queue_string(1'b0);
		str_q.push_back(8'hFF);
		queue_string(1'b0);
		// upper case escape, forced space, plus
		append_text("%4A%1f+");
		queue_string(1'b0);
		// failed entity restarting on a second ampersand, trailing percent
		append_text("&&gt;%");
		queue_string(1'b0);
		// broken escape, kept value 1, trailing escape with one digit
		append_text("%zx%01%4");
		queue_string(1'b0);

		while (rand_items < RANDOM_ITEMS) begin
			repeat ($urandom_range(1, 6)) add_random_token();
			case ($urandom_range(0, 5))
				0: str_q.push_back(CH_PCT);
				1: begin
					str_q.push_back(CH_PCT);
					str_q.push_back(rand_hex());
				end
				2: begin
					n = ent_name[$urandom_range(0, 4)];
					append_text(n.substr(0, $urandom_range(0, n.len() - 2)));
				end
				default: ;
			endcase
			rand_items += str_q.size();
			queue_string(str_cnt % 8 == 0);
			str_cnt++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (enc_q.size() != 0 || enc_if.valid) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && decoded_q.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// encoded request driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_if.valid <= 1'b0;
			enc_if.in_byte <= '0;
			enc_if.in_last <= 1'b0;
		end else begin
			if (enc_if.valid && enc_if.ready) begin
				decode_byte(enc_if.in_byte, enc_if.in_last);
				in_gap = draw_gap(in_calm);
			end
			if (!(enc_if.valid && !enc_if.ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					enc_if.valid <= 1'b0;
				end else if (enc_q.size() != 0 && !(enc_q[0].drain && decoded_q.size() != 0)) begin
					cur = enc_q.pop_front();
					enc_if.valid <= 1'b1;
					enc_if.in_byte <= cur.b;
					enc_if.in_last <= cur.last;
				end else begin
					enc_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// decoded request monitor
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_if.ready <= 1'b0;
		end else begin
			if (dec_if.valid && dec_if.ready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected decoded byte %02h last %0d", $time,
						dec_if.out_byte, dec_if.out_last);
					err_cnt++;
				end else begin
					want = decoded_q.pop_front();
					if (dec_if.out_byte !== want.b) begin
						$display("%0t: out_byte expected %02h actual %02h", $time,
							want.b, dec_if.out_byte);
						err_cnt++;
					end
					if (dec_if.out_last !== want.last) begin
						$display("%0t: out_last expected %0d actual %0d", $time,
							want.last, dec_if.out_last);
						err_cnt++;
					end
				end
				out_stall = draw_gap(out_calm);
			end else if (out_stall > 0) begin
				out_stall--;
			end
			dec_if.ready <= (out_stall == 0);
		end
	end

endmodule
